// ----- rtl/sba_pkg.sv -----
package sba_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_OOM     = 3'd1,
        ST_FREED   = 3'd2,
        ST_INVALID = 3'd3,
        ST_ZERO    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam int unsigned CFG_IDX_W      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BASE = 8'd1;

    localparam logic [31:0] SLAB_BASE_RST  = 32'h0010_0000;
    localparam logic [31:0] BLOCK_BASE_RST = 32'h0020_0000;

    localparam int unsigned SLOT_SHIFT  = 9;
    localparam int unsigned CLASS_SHIFT = 16;
    localparam int unsigned BLOCK_SHIFT = 20;
    localparam logic [31:0] BLOCK_CAPACITY = 32'h0010_0000;

    localparam int unsigned MAX_CLASSES = 5;
    localparam logic [8:0] CLASS_BYTES [MAX_CLASSES] = '{
        9'd16, 9'd32, 9'd64, 9'd128, 9'd256
    };
    localparam logic [2:0] NO_CLASS    = 3'd0;
    localparam logic [2:0] BLOCK_CLASS = 3'd5;

    // decoded request held between the read and the write-back cycle
    typedef struct packed {
        t_opcode     op;
        logic        zero;
        logic [2:0]  cls;
        logic        slab_ok;
        logic [6:0]  slot;
        logic        blk_ok;
        logic [5:0]  blk;
        logic        fits_blk;
        logic [31:0] cls_base;
    } t_req;

endpackage

// ----- rtl/sba_pick.sv -----
module sba_pick
    import sba_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic [WIDTH-1:0]                      i_bits,
    output logic                                  o_found,
    output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] o_index
);

    localparam int unsigned IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // lowest set bit wins
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_found = 1'b1;
                o_index = IW'(i);
            end
        end
    end

endmodule

// ----- rtl/sba_slab_mem.sv -----
module sba_slab_mem
    import sba_pkg::*;
#(
    parameter int unsigned DEPTH = 5,
    parameter int unsigned WIDTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // per-entry valid bits stand in for clearing the array at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- rtl/sba_decode.sv -----
module sba_decode
    import sba_pkg::*;
#(
    parameter int unsigned SLOTS_PER_CLASS = 32,
    parameter int unsigned BLOCK_COUNT     = 64,
    parameter int unsigned CLASS_COUNT     = 5
) (
    input  logic        i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_free_address,
    input  logic [31:0] i_slab_base,
    input  logic [31:0] i_block_base,
    output t_req        o_req
);

    localparam logic [31:0] SLAB_SPAN  = 32'(CLASS_COUNT) << CLASS_SHIFT;
    localparam logic [6:0]  SLOT_LIMIT = 7'(SLOTS_PER_CLASS - 1);
    localparam logic [11:0] BLK_LIMIT  = 12'(BLOCK_COUNT - 1);

    logic [31:0] slab_off;
    logic [31:0] blk_off;
    logic [2:0]  size_cls;
    logic        size_hit;
    logic [2:0]  cls;

    assign slab_off = i_free_address - i_slab_base;
    assign blk_off  = i_free_address - i_block_base;

    // smallest class that holds the size
    always_comb begin
        size_cls = NO_CLASS;
        size_hit = 1'b0;
        for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
            if (i_request_size <= 32'(CLASS_BYTES[c])) begin
                size_cls = 3'(c);
                size_hit = 1'b1;
            end
        end
    end

    always_comb begin
        o_req          = '0;
        o_req.op       = t_opcode'(i_opcode);
        o_req.fits_blk = (i_request_size <= BLOCK_CAPACITY);
        o_req.slot     = slab_off[SLOT_SHIFT +: 7];
        o_req.blk      = blk_off[BLOCK_SHIFT +: 6];
        o_req.blk_ok   = (blk_off[BLOCK_SHIFT-1:0] == '0)
                         && (blk_off[31:BLOCK_SHIFT] <= BLK_LIMIT);
        if (t_opcode'(i_opcode) == OP_ALLOC) begin
            cls           = size_cls;
            o_req.zero    = (i_request_size == '0);
            o_req.slab_ok = size_hit && (i_request_size != '0)
                            && (32'(size_cls) < 32'(CLASS_COUNT));
        end else begin
            cls           = slab_off[CLASS_SHIFT +: 3];
            o_req.zero    = (i_free_address == '0);
            o_req.slab_ok = (slab_off < SLAB_SPAN)
                            && (slab_off[SLOT_SHIFT-1:0] == '0)
                            && (slab_off[CLASS_SHIFT-1:SLOT_SHIFT] <= 16'(SLOT_LIMIT));
        end
        o_req.cls      = cls;
        o_req.cls_base = i_slab_base + (32'(cls) << CLASS_SHIFT);
    end

endmodule

// ----- rtl/slab_and_block_allocator.sv -----
// slab and block allocator
//
// request channel (i_req_valid / o_req_ready) carries an allocate or free
// request: opcode, request_size, free_address. response channel
// (o_rsp_valid / i_rsp_ready) returns result_address, status, size_class,
// exactly one response per request, in order. config channel
// (i_cfg_valid / o_cfg_ready, always ready) writes slab_base (index 0) or
// block_base (index 1); other indexes are dropped.
//
// the accept cycle reads the class's used-map word from the slab map
// memory; the execute state then priority-encodes it (and the block map),
// writes the word back and loads the response register. a new request is
// taken only in idle, once the execute state of the last one has ended,
// as set by the read/modify/write of the used-map memory.
// a new request can be taken while a response waits; if the receiver
// stalls, the following request holds in its execute cycle until the
// response register drains.
// reset clears both maps at once (valid bits) and restores the bases;
// no clearing pass, the block is ready right after reset.
module slab_and_block_allocator
    import sba_pkg::*;
#(
    parameter int unsigned SLOTS_PER_CLASS = 32,
    parameter int unsigned BLOCK_COUNT     = 64,
    parameter int unsigned CLASS_COUNT     = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // requests
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic                 i_opcode,
    input  logic [31:0]          i_request_size,
    input  logic [31:0]          i_free_address,
    // responses
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [31:0]          o_result_address,
    output logic [2:0]           o_status,
    output logic [2:0]           o_size_class
);

    localparam int unsigned SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
    localparam int unsigned BLK_W  = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int unsigned CLS_AW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    t_state r_state, n_state;
    t_req   r_req, dec_req;

    logic [31:0] r_slab_base;
    logic [31:0] r_block_base;
    logic [BLOCK_COUNT-1:0] r_blk_map, n_blk_map;

    logic        r_rsp_valid;
    logic [31:0] r_addr, n_addr;
    t_status     r_status, n_status;
    logic [2:0]  r_class, n_class;

    logic req_fire;
    logic exec_go;
    logic rd_en;

    logic [SLOTS_PER_CLASS-1:0] slab_word;
    logic [SLOTS_PER_CLASS-1:0] slab_wdata;
    logic                       slab_we;
    logic                       slab_free_found;
    logic [SLOT_W-1:0]          slab_free_idx;
    logic                       blk_free_found;
    logic [BLK_W-1:0]           blk_free_idx;
    logic [SLOT_W-1:0]          req_slot;
    logic [BLK_W-1:0]           req_blk;

    assign o_cfg_ready = 1'b1;
    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    // execute only when the response register is free or draining
    assign exec_go     = (r_state == S_EXEC) && (!r_rsp_valid || i_rsp_ready);

    sba_decode #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS),
        .BLOCK_COUNT     (BLOCK_COUNT),
        .CLASS_COUNT     (CLASS_COUNT)
    ) u_decode (
        .i_opcode       (i_opcode),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .i_slab_base    (r_slab_base),
        .i_block_base   (r_block_base),
        .o_req          (dec_req)
    );

    // read the used-map word only when the class is meaningful
    assign rd_en = req_fire && dec_req.slab_ok && !dec_req.zero;

    sba_slab_mem #(
        .DEPTH (CLASS_COUNT),
        .WIDTH (SLOTS_PER_CLASS)
    ) u_slab_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (dec_req.cls[CLS_AW-1:0]),
        .o_rd_data (slab_word),
        .i_wr_en   (slab_we),
        .i_wr_addr (r_req.cls[CLS_AW-1:0]),
        .i_wr_data (slab_wdata)
    );

    sba_pick #(
        .WIDTH (SLOTS_PER_CLASS)
    ) u_pick_slot (
        .i_bits  (~slab_word),
        .o_found (slab_free_found),
        .o_index (slab_free_idx)
    );

    sba_pick #(
        .WIDTH (BLOCK_COUNT)
    ) u_pick_blk (
        .i_bits  (~r_blk_map),
        .o_found (blk_free_found),
        .o_index (blk_free_idx)
    );

    assign req_slot = r_req.slot[SLOT_W-1:0];
    assign req_blk  = r_req.blk[BLK_W-1:0];

    // modify step of the read/modify/write
    always_comb begin
        n_state    = r_state;
        slab_we    = 1'b0;
        slab_wdata = slab_word;
        n_blk_map  = r_blk_map;
        n_addr     = '0;
        n_status   = ST_ZERO;
        n_class    = NO_CLASS;
        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                    if (r_req.zero) begin
                        // zero size or null free
                        n_status = ST_ZERO;
                    end else if (r_req.op == OP_ALLOC) begin
                        if (r_req.slab_ok && slab_free_found) begin
                            slab_we    = 1'b1;
                            slab_wdata = slab_word
                                         | (SLOTS_PER_CLASS'(1) << slab_free_idx);
                            n_addr     = r_req.cls_base
                                         + (32'(slab_free_idx) << SLOT_SHIFT);
                            n_status   = ST_ALLOC;
                            n_class    = r_req.cls;
                        end else if (r_req.fits_blk && blk_free_found) begin
                            // class full or too large: fall back to a block
                            n_blk_map  = r_blk_map | (BLOCK_COUNT'(1) << blk_free_idx);
                            n_addr     = r_block_base
                                         + (32'(blk_free_idx) << BLOCK_SHIFT);
                            n_status   = ST_ALLOC;
                            n_class    = BLOCK_CLASS;
                        end else begin
                            n_status = ST_OOM;
                        end
                    end else begin
                        if (r_req.slab_ok && slab_word[req_slot]) begin
                            slab_we    = 1'b1;
                            slab_wdata = slab_word & ~(SLOTS_PER_CLASS'(1) << req_slot);
                            n_status   = ST_FREED;
                            n_class    = r_req.cls;
                        end else if (r_req.blk_ok && r_blk_map[req_blk]) begin
                            n_blk_map  = r_blk_map & ~(BLOCK_COUNT'(1) << req_blk);
                            n_status   = ST_FREED;
                            n_class    = BLOCK_CLASS;
                        end else begin
                            n_status = ST_INVALID;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_blk_map    <= '0;
            r_rsp_valid  <= 1'b0;
            r_slab_base  <= SLAB_BASE_RST;
            r_block_base <= BLOCK_BASE_RST;
        end else begin
            r_state   <= n_state;
            r_blk_map <= n_blk_map;
            if (exec_go) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SLAB_BASE) begin
                    r_slab_base <= i_cfg_data;
                end else if (i_cfg_index == CFG_BLOCK_BASE) begin
                    r_block_base <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= dec_req;
        end
        if (exec_go) begin
            r_addr   <= n_addr;
            r_status <= n_status;
            r_class  <= n_class;
        end
    end

    assign o_rsp_valid      = r_rsp_valid;
    assign o_result_address = r_addr;
    assign o_status         = r_status;
    assign o_size_class     = r_class;

endmodule

// ----- rtl/sba_chk.sv -----
module sba_chk
    import sba_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 o_req_ready,
    input logic                 o_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [31:0]          o_result_address,
    input logic [2:0]           o_status,
    input logic [2:0]           o_size_class
);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_result_address)
            && $stable(o_status) && $stable(o_size_class))
        else $error("response dropped or changed while stalled");

    // only a grant carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status != ST_ALLOC) |-> o_result_address == '0)
        else $error("address on a non-grant response");

    // failures report class zero
    a_fail_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status == ST_OOM || o_status == ST_INVALID
            || o_status == ST_ZERO) |-> o_size_class == NO_CLASS)
        else $error("class reported on a failed request");

    // one request in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in execution");

    // a grant or a free names a slab class or the block region
    a_grant_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status == ST_ALLOC || o_status == ST_FREED)
            |-> o_size_class <= BLOCK_CLASS)
        else $error("bad class on a successful response");

endmodule

bind slab_and_block_allocator sba_chk u_sba_chk (.*);
